### rtl/core/generational_handle_table_assert.svh
// assertion macros used by the checker file
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define GHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define GHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also checks the reset itself
`define GHT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ght_pkg.sv
package ght_pkg;

  localparam int NUM_SLOTS_DEF    = 256;
  localparam int SEGMENT_BITS_DEF = 32;
  localparam int DATA_WIDTH_DEF   = 32;

  localparam int IDX_W      = 8;
  localparam int GEN_W      = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_GET   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_t;

endpackage

### rtl/core/ght_if.sv
interface ght_in_if;
  import ght_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [IDX_W-1:0]     handle_index;
  logic [GEN_W-1:0]     handle_generation;
  logic [GEN_W-1:0]     write_data;

  modport source (
    output valid, action, handle_index, handle_generation, write_data,
    input  ready
  );
  modport sink (
    input  valid, action, handle_index, handle_generation, write_data,
    output ready
  );
endinterface

interface ght_out_if;
  import ght_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [IDX_W-1:0]      new_index;
  logic [GEN_W-1:0]      new_generation;
  logic [OUT_DATA_W-1:0] read_data;

  modport source (
    output valid, status, new_index, new_generation, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, new_index, new_generation, read_data,
    output ready
  );
endinterface

### rtl/core/ght_ram.sv
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/generational_handle_table.sv
// channel  dir  fields                                                  handshake
// in_ch    in   action, handle_index, handle_generation, write_data     valid/ready
// out_ch   out  status, new_index, new_generation, read_data            valid/ready
//
// free, get and the unused code are accepted in S_IDLE, then read and written back in S_EVAL.
// allocate also steps over the full segments from the lowest possibly free one, at most
// NUM_SEGS - 1 of them, one occupancy word a cycle.
// after reset the occupancy memory is zeroed, one word a cycle, with ready low.
// a result waits in the output register; the next item is taken meanwhile and holds in
// its last cycle until that register is free.
module generational_handle_table #(
  parameter int NUM_SLOTS    = ght_pkg::NUM_SLOTS_DEF,
  parameter int SEGMENT_BITS = ght_pkg::SEGMENT_BITS_DEF,
  parameter int DATA_WIDTH   = ght_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ght_in_if.sink    in_ch,
  ght_out_if.source out_ch
);
  import ght_pkg::*;

  localparam int NUM_SEGS  = (NUM_SLOTS + SEGMENT_BITS - 1) / SEGMENT_BITS;
  localparam int SEG_AW    = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int BIT_AW    = $clog2(SEGMENT_BITS);
  localparam int SLOT_AW   = $clog2(NUM_SLOTS);
  localparam int LAST_BITS = NUM_SLOTS - (NUM_SEGS - 1) * SEGMENT_BITS;
  localparam int HX_W      = (SLOT_AW > IDX_W) ? SLOT_AW : IDX_W;
  localparam int DX_W      = (DATA_WIDTH > OUT_DATA_W) ? DATA_WIDTH : OUT_DATA_W;
  localparam int SLOT_W    = GEN_W + DATA_WIDTH;
  localparam int LUT_N     = 2 ** IDX_W;

  // constant tables: segment, bit offset and range flag of every handle index
  logic [SEG_AW-1:0]       seg_lut [LUT_N];
  logic [BIT_AW-1:0]       bit_lut [LUT_N];
  logic                    rng_lut [LUT_N];
  logic [SEGMENT_BITS-1:0] pad_mask;

  for (genvar i = 0; i < LUT_N; i++) begin : g_lut
    assign seg_lut[i] = SEG_AW'(i / SEGMENT_BITS);
    assign bit_lut[i] = BIT_AW'(i % SEGMENT_BITS);
    assign rng_lut[i] = (i < NUM_SLOTS);
  end

  // slots past the capacity in the last segment read as taken
  for (genvar b = 0; b < SEGMENT_BITS; b++) begin : g_pad
    assign pad_mask[b] = (b >= LAST_BITS);
  end

  state_t                state_r, state_nxt;
  action_t               act_r, act_nxt;
  logic [IDX_W-1:0]      hidx_r, hidx_nxt;
  logic [GEN_W-1:0]      hgen_r, hgen_nxt;
  logic [DATA_WIDTH-1:0] wdata_r, wdata_nxt;
  logic [SEG_AW-1:0]     seg_r, seg_nxt;
  logic [SEG_AW-1:0]     hint_r, hint_nxt;
  logic [SEG_AW-1:0]     clr_r, clr_nxt;
  logic [GEN_W-1:0]      gen_ctr_r, gen_ctr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [IDX_W-1:0]      out_index_r, out_index_nxt;
  logic [GEN_W-1:0]      out_gen_r, out_gen_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                    occ_we;
  logic [SEG_AW-1:0]       occ_waddr, occ_raddr;
  logic [SEGMENT_BITS-1:0] occ_wdata, occ_rdata;
  logic                    slot_we;
  logic [SLOT_AW-1:0]      slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]       slot_wdata, slot_rdata;

  logic                    accept;
  logic                    out_free;
  logic                    finish;
  logic                    last_seg;
  logic [SEGMENT_BITS-1:0] occ_word;
  logic                    seg_full;
  logic [BIT_AW-1:0]       ffz;
  logic [SLOT_AW-1:0]      slot_new;
  logic [GEN_W-1:0]        gen_inc, gen_next;
  logic [IDX_W-1:0]        hidx_sel;
  logic [HX_W-1:0]         hidx_ext;
  logic [BIT_AW-1:0]       h_bit;
  logic                    h_in;
  logic                    busy;
  logic                    gen_ok;
  logic [GEN_W-1:0]        rd_gen;
  logic [DX_W-1:0]         rd_data_ext;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign last_seg = (seg_r == SEG_AW'(NUM_SEGS - 1));
  assign occ_word = occ_rdata | (last_seg ? pad_mask : '0);
  assign seg_full = &occ_word;

  // lowest zero in the segment
  always_comb begin
    ffz = '0;
    for (int b = SEGMENT_BITS - 1; b >= 0; b--) begin
      if (!occ_word[b]) begin
        ffz = BIT_AW'(b);
      end
    end
  end

  assign slot_new = SLOT_AW'(seg_r) * SLOT_AW'(SEGMENT_BITS) + SLOT_AW'(ffz);

  // generation counter skips zero on wrap
  assign gen_inc  = gen_ctr_r + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  assign hidx_sel = (state_r == S_IDLE) ? in_ch.handle_index : hidx_r;
  assign hidx_ext = HX_W'(hidx_sel);
  assign h_bit    = bit_lut[hidx_r];
  assign h_in     = rng_lut[hidx_r];
  assign rd_gen   = slot_rdata[SLOT_W-1:DATA_WIDTH];
  assign busy     = occ_rdata[h_bit];
  assign gen_ok   = (rd_gen == hgen_r);
  assign rd_data_ext = DX_W'(slot_rdata[DATA_WIDTH-1:0]);

  assign finish = (state_r == S_EVAL) && out_free &&
                  ((act_r != ACT_ALLOC) || !seg_full || last_seg);

  // occupancy read address: hint or handle segment at accept, next word while scanning
  always_comb begin
    occ_raddr = seg_r;
    if (state_r == S_IDLE) begin
      occ_raddr = (action_t'(in_ch.action) == ACT_ALLOC) ? hint_r
                                                          : seg_lut[in_ch.handle_index];
    end else if (state_r == S_EVAL && act_r == ACT_ALLOC && seg_full && !last_seg) begin
      occ_raddr = seg_r + SEG_AW'(1);
    end
  end

  assign slot_raddr = hidx_ext[SLOT_AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == SEG_AW'(NUM_SEGS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath, memory writes and result
  always_comb begin
    act_nxt        = act_r;
    hidx_nxt       = hidx_r;
    hgen_nxt       = hgen_r;
    wdata_nxt      = wdata_r;
    seg_nxt        = occ_raddr;
    hint_nxt       = hint_r;
    clr_nxt        = clr_r;
    gen_ctr_nxt    = gen_ctr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_gen_nxt    = out_gen_r;
    out_data_nxt   = out_data_r;
    occ_we         = 1'b0;
    occ_waddr      = seg_r;
    occ_wdata      = occ_rdata;
    slot_we        = 1'b0;
    slot_waddr     = slot_new;
    slot_wdata     = {gen_next, wdata_r};

    unique case (state_r)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_r;
        occ_wdata = '0;
        clr_nxt   = clr_r + SEG_AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt   = action_t'(in_ch.action);
          hidx_nxt  = in_ch.handle_index;
          hgen_nxt  = in_ch.handle_generation;
          wdata_nxt = DATA_WIDTH'(in_ch.write_data);
        end
      end
      S_EVAL: begin
        if (finish) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = '0;
          out_gen_nxt    = '0;
          out_data_nxt   = '0;
          case (act_r)
            ACT_ALLOC: begin
              if (seg_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                occ_we        = 1'b1;
                occ_wdata     = occ_rdata | (SEGMENT_BITS'(1) << ffz);
                slot_we       = 1'b1;
                gen_ctr_nxt   = gen_next;
                hint_nxt      = seg_r;
                out_index_nxt = IDX_W'(slot_new);
                out_gen_nxt   = gen_next;
              end
            end
            ACT_FREE, ACT_GET: begin
              if (!h_in) begin
                out_status_nxt = ST_RANGE;
              end else if (!busy || !gen_ok) begin
                out_status_nxt = ST_STALE;
              end else begin
                out_data_nxt = rd_data_ext[OUT_DATA_W-1:0];
                if (act_r == ACT_FREE) begin
                  occ_we    = 1'b1;
                  occ_wdata = occ_rdata & ~(SEGMENT_BITS'(1) << h_bit);
                  if (seg_r < hint_r) begin
                    hint_nxt = seg_r;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hint_r      <= '0;
      gen_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      gen_ctr_r   <= gen_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    hidx_r       <= hidx_nxt;
    hgen_r       <= hgen_nxt;
    wdata_r      <= wdata_nxt;
    seg_r        <= seg_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_gen_r    <= out_gen_nxt;
    out_data_r   <= out_data_nxt;
  end

  ght_ram #(
    .WIDTH (SEGMENT_BITS),
    .DEPTH (NUM_SEGS),
    .AW    (SEG_AW)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  // generation and data of each slot side by side
  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.new_index      = out_index_r;
  assign out_ch.new_generation = out_gen_r;
  assign out_ch.read_data      = out_data_r;

endmodule

### rtl/core/ght_checker.sv
`include "generational_handle_table_assert.svh"

module ght_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_status,
  input logic [ght_pkg::IDX_W-1:0]      out_new_index,
  input logic [ght_pkg::GEN_W-1:0]      out_new_generation,
  input logic [ght_pkg::OUT_DATA_W-1:0] out_read_data
);
  import ght_pkg::*;

  // reset leaves nothing to deliver and the clear pass keeps input closed
  `GHT_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid && !in_ready, "busy right after reset")

  // one item at a time: no accept in the cycle after an accept
  `GHT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ready right after accept")

  // a failed item reports nothing but its status
  `GHT_ASSERT_IMP(a_fail_clean, out_valid && (out_status != ST_OK), (out_new_index == '0) && (out_new_generation == '0) && (out_read_data == '0), "error result carries data")

  `GHT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_new_generation) && $stable(out_read_data), "stalled result changed")

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_new_index      (out_ch.new_index),
  .out_new_generation (out_ch.new_generation),
  .out_read_data      (out_ch.read_data)
);
